FILE: rtl/kemq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_pkg: shared types and constants for the keyed multi-ring event queue
// Sizes of the slot table and rings, request/result transactions, and the
// decoded command that travels from the front end to the execution engine.
// ----------------------------------------------------------------------------
package kemq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int NUM_TARGETS = 8;
  localparam int BATCH_MAX   = 32;
  localparam int EVENT_WIDTH = 64;

  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W     = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int BCNT_W     = $clog2(BATCH_MAX + 1);
  localparam int N_W        = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
  localparam int RING_DEPTH = NUM_TARGETS * QUEUE_DEPTH;
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_DRAIN = 2'd1,
    REQ_DROP  = 2'd2
  } kemq_op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] target_id;
    logic [63:0] event_data;
    logic [7:0]  drain_limit;
  } kemq_req_t;

  typedef struct packed {
    logic [63:0] out_event;
    logic [5:0]  batch_count;
    logic        has_event;
    logic        is_last;
  } kemq_rsp_t;

  typedef struct packed {
    kemq_op_e                op;
    logic [15:0]             key;
    logic [EVENT_WIDTH-1:0]  data;
    logic [BCNT_W-1:0]       limit;
  } kemq_cmd_t;

endpackage

FILE: rtl/keyed_multi_ring_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_multi_ring_event_queue: per-target event rings with keyed lookup
// Push, drain and drop transactions on a table of overwrite-oldest rings.
// ----------------------------------------------------------------------------
// Flow: the engine runs one command at a time from the command queue, via
//   its command register; push and drop take effect in the lookup state,
//   where an empty drain also registers its marker result, and a drain of n
//   events streams them one per cycle from the drain state.
//   busy rises when the 2-entry command queue is full. The receiver cannot stall.
// Reset: slot table empty, pointers and counts zero; ring contents undefined.
// ----------------------------------------------------------------------------
module keyed_multi_ring_event_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kemq_pkg::kemq_req_t req_i,
  output logic                rsp_strobe_o,
  output kemq_pkg::kemq_rsp_t rsp_o
);
  import kemq_pkg::*;

  // front end -> command queue
  logic      fe_push;
  kemq_cmd_t fe_cmd;
  // command queue -> engine
  kemq_cmd_t q_cmd;
  logic      q_empty, q_full, q_pop;

  // Decode qualifies the transaction; unknown opcodes are swallowed here so
  // the engine only sees push, drain and drop.
  kemq_front u_front (
    .start_i (start),
    .full_i  (q_full),
    .req_i   (req_i),
    .push_o  (fe_push),
    .cmd_o   (fe_cmd)
  );

  // Queue decouples acceptance from the engine while it streams a drain.
  kemq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Engine owns the slot table and ring memory; results are registered.
  kemq_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .rsp_strobe_o (rsp_strobe_o),
    .rsp_o        (rsp_o)
  );

  assign busy = q_full;

endmodule

FILE: rtl/kemq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_front: request decode
// Qualifies incoming transactions, drops unknown opcodes, clamps the drain
// limit and trims the payload before the command enters the queue.
// ----------------------------------------------------------------------------
module kemq_front (
  input  logic                start_i,
  input  logic                full_i,
  input  kemq_pkg::kemq_req_t req_i,
  output logic                push_o,
  output kemq_pkg::kemq_cmd_t cmd_o
);
  import kemq_pkg::*;

  logic known;

  always_comb begin
    unique case (req_i.req_type)
      REQ_PUSH, REQ_DRAIN, REQ_DROP: known = 1'b1;
      default:                       known = 1'b0;
    endcase
  end

  assign push_o     = start_i && !full_i && known;
  assign cmd_o.op   = kemq_op_e'(req_i.req_type);
  assign cmd_o.key  = req_i.target_id;
  assign cmd_o.data = req_i.event_data[EVENT_WIDTH-1:0];
  // limit clamped to the batch maximum
  assign cmd_o.limit = (req_i.drain_limit > 8'(BATCH_MAX)) ? BCNT_W'(BATCH_MAX)
                                                            : BCNT_W'(req_i.drain_limit);

endmodule

FILE: rtl/kemq_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_cmd_fifo: command queue
// Short queue between the decode front end and the execution engine.
// ----------------------------------------------------------------------------
module kemq_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kemq_pkg::kemq_cmd_t cmd_i,
  input  logic                pop_i,
  output kemq_pkg::kemq_cmd_t cmd_o,
  output logic                empty_o,
  output logic                full_o
);
  import kemq_pkg::*;

  kemq_cmd_t               entry_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CNT_W-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/kemq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_engine: slot table and ring execution
// Resolves the slot for each command, writes pushes into the ring memory,
// frees slots on drop and streams drained events one per cycle.
// ----------------------------------------------------------------------------
module kemq_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kemq_pkg::kemq_cmd_t cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                rsp_strobe_o,
  output kemq_pkg::kemq_rsp_t rsp_o
);
  import kemq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_DRAIN  = 3'b100
  } kemq_state_e;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  kemq_state_e            st_q;
  kemq_cmd_t              cmd_q;
  logic [NUM_TARGETS-1:0] used_q;
  logic [15:0]            key_q  [NUM_TARGETS];
  logic [PTR_W-1:0]       wptr_q [NUM_TARGETS];
  logic [PTR_W-1:0]       rptr_q [NUM_TARGETS];
  logic [CNT_W-1:0]       cnt_q  [NUM_TARGETS];
  logic [SLOT_W-1:0]      slot_q;
  logic [BCNT_W-1:0]      left_q, n_q;

  logic [EVENT_WIDTH-1:0] ring_mem [RING_DEPTH];
  logic [EVENT_WIDTH-1:0] rd_data_q;
  logic                   rsp_vld_q, rsp_has_q, rsp_last_q;
  logic [BCNT_W-1:0]      rsp_cnt_q;

  logic [NUM_TARGETS-1:0] hit_v, free_v, ctrl_v;
  logic [SLOT_W-1:0]      hit_idx, free_idx, ctrl_idx, tgt_idx, cur_slot;
  logic                   tgt_ok, claim;
  logic [PTR_W-1:0]       cur_wp, cur_rp;
  logic [CNT_W-1:0]       cur_cnt;
  logic [N_W-1:0]         n_wide;
  logic [BCNT_W-1:0]      n_val;
  logic [ADDR_W-1:0]      mem_addr;
  logic                   wr_en, rd_en;

  // slot match / free / controller search, lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    ctrl_idx = '0;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      hit_v[i]  = used_q[i] && (key_q[i] == cmd_q.key);
      free_v[i] = !used_q[i];
      ctrl_v[i] = used_q[i] && (key_q[i] == 16'd0);
    end
    for (int i = NUM_TARGETS - 1; i >= 0; i--) begin
      if (hit_v[i])  hit_idx  = SLOT_W'(i);
      if (free_v[i]) free_idx = SLOT_W'(i);
      if (ctrl_v[i]) ctrl_idx = SLOT_W'(i);
    end
  end

  always_comb begin
    tgt_ok  = 1'b0;
    tgt_idx = hit_idx;
    claim   = 1'b0;
    case (cmd_q.op)
      REQ_PUSH: begin
        if (|hit_v) begin
          tgt_ok = 1'b1;
        end else if (|free_v) begin
          tgt_ok  = 1'b1;
          tgt_idx = free_idx;
          claim   = 1'b1;
        end else if (|ctrl_v) begin
          tgt_ok  = 1'b1;
          tgt_idx = ctrl_idx;
        end
      end
      REQ_DRAIN: tgt_ok = |hit_v;
      REQ_DROP:  tgt_ok = |hit_v && (cmd_q.key != 16'd0);
      default:   tgt_ok = 1'b0;
    endcase
  end

  assign cur_slot = (st_q == ST_DRAIN) ? slot_q : tgt_idx;
  assign cur_wp   = claim ? '0 : wptr_q[cur_slot];
  assign cur_rp   = claim ? '0 : rptr_q[cur_slot];
  assign cur_cnt  = claim ? '0 : cnt_q[cur_slot];

  assign n_wide = (N_W'(cur_cnt) < N_W'(cmd_q.limit)) ? N_W'(cur_cnt) : N_W'(cmd_q.limit);
  assign n_val  = BCNT_W'(n_wide);

  assign mem_addr = ADDR_W'(cur_slot) * ADDR_W'(QUEUE_DEPTH)
                  + ADDR_W'((st_q == ST_DRAIN) ? cur_rp : cur_wp);
  assign wr_en    = (st_q == ST_LOOKUP) && (cmd_q.op == REQ_PUSH) && tgt_ok;
  assign rd_en    = (st_q == ST_DRAIN);

  assign cmd_pop_o = (st_q == ST_IDLE) && !cmd_empty_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[mem_addr] <= cmd_q.data;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (wr_en && claim) begin
      key_q[cur_slot] <= cmd_q.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      used_q     <= '0;
      slot_q     <= '0;
      left_q     <= '0;
      n_q        <= '0;
      rsp_vld_q  <= 1'b0;
      rsp_has_q  <= 1'b0;
      rsp_last_q <= 1'b0;
      rsp_cnt_q  <= '0;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      rsp_vld_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            st_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          st_q <= ST_IDLE;
          case (cmd_q.op)
            REQ_PUSH: begin
              if (tgt_ok) begin
                used_q[cur_slot] <= 1'b1;
                wptr_q[cur_slot] <= next_ptr(cur_wp);
                if (cur_cnt < CNT_W'(QUEUE_DEPTH)) begin
                  cnt_q[cur_slot]  <= cur_cnt + 1'b1;
                  rptr_q[cur_slot] <= cur_rp;
                end else begin
                  rptr_q[cur_slot] <= next_ptr(cur_rp);
                end
              end
            end
            REQ_DRAIN: begin
              if (tgt_ok && (n_val != '0)) begin
                st_q   <= ST_DRAIN;
                slot_q <= cur_slot;
                left_q <= n_val;
                n_q    <= n_val;
              end else begin
                // empty drain: single marker transaction
                rsp_vld_q  <= 1'b1;
                rsp_has_q  <= 1'b0;
                rsp_last_q <= 1'b1;
                rsp_cnt_q  <= '0;
              end
            end
            REQ_DROP: begin
              if (tgt_ok) begin
                used_q[cur_slot] <= 1'b0;
                wptr_q[cur_slot] <= '0;
                rptr_q[cur_slot] <= '0;
                cnt_q[cur_slot]  <= '0;
              end
            end
            default: st_q <= ST_IDLE;
          endcase
        end
        ST_DRAIN: begin
          rptr_q[cur_slot] <= next_ptr(cur_rp);
          cnt_q[cur_slot]  <= cur_cnt - 1'b1;
          left_q           <= left_q - 1'b1;
          rsp_vld_q        <= 1'b1;
          rsp_has_q        <= 1'b1;
          rsp_last_q       <= (left_q == BCNT_W'(1));
          rsp_cnt_q        <= n_q;
          if (left_q == BCNT_W'(1)) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_strobe_o      = rsp_vld_q;
  assign rsp_o.out_event   = rsp_has_q ? 64'(rd_data_q) : 64'd0;
  assign rsp_o.batch_count = 6'(rsp_cnt_q);
  assign rsp_o.has_event   = rsp_has_q;
  assign rsp_o.is_last     = rsp_last_q;

endmodule

FILE: rtl/kemq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_checker: port-level checks for the keyed multi-ring event queue
// Watches result transactions for drain framing and empty-drain encoding.
// ----------------------------------------------------------------------------
module kemq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_strobe_o,
  input kemq_pkg::kemq_rsp_t rsp_o
);
  import kemq_pkg::*;

  // empty drain carries a zero payload and closes the batch
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && !rsp_o.has_event |->
      rsp_o.is_last && (rsp_o.batch_count == 6'd0) && (rsp_o.out_event == 64'd0))
    else $error("empty drain result malformed");

  // a batch streams without gaps and keeps its count
  a_batch_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && rsp_o.has_event && !rsp_o.is_last |=>
      rsp_strobe_o && rsp_o.has_event && (rsp_o.batch_count == $past(rsp_o.batch_count)))
    else $error("drain batch broken");

  // the engine returns to idle after a batch, so no result follows its end directly
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o && rsp_o.is_last |=> !rsp_strobe_o)
    else $error("result right after end of batch");

  // batch size never exceeds the clamp
  a_batch_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_strobe_o |-> (int'(rsp_o.batch_count) <= BATCH_MAX))
    else $error("batch count above maximum");

endmodule

bind keyed_multi_ring_event_queue kemq_checker u_kemq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_strobe_o (rsp_strobe_o),
  .rsp_o        (rsp_o)
);

FILE: verif/kemq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemq_scoreboard: predictor and result checker for the keyed event queue
// Watches accepted request transactions, tracks its own copy of the slot
// table and rings, and compares each result strobe against the oldest
// predicted event.
// ----------------------------------------------------------------------------
module kemq_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  kemq_pkg::kemq_req_t req_i,
  input  logic                rsp_strobe_i,
  input  kemq_pkg::kemq_rsp_t rsp_i,
  input  logic                end_check_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o
);
  import kemq_pkg::*;

  logic                   slot_used [NUM_TARGETS];
  logic [15:0]            slot_key  [NUM_TARGETS];
  logic [EVENT_WIDTH-1:0] ring_mem  [NUM_TARGETS][QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr    [NUM_TARGETS];
  logic [PTR_W-1:0]       rd_ptr    [NUM_TARGETS];
  logic [CNT_W-1:0]       fill_cnt  [NUM_TARGETS];

  kemq_rsp_t drained_q [$];
  int        mismatch_cnt = 0;
  logic      end_checked  = 1'b0;

  assign mismatch_cnt_o = mismatch_cnt;

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (int'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + 1'b1;
  endfunction

  function automatic int find_ring(logic [15:0] key);
    for (int i = 0; i < NUM_TARGETS; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // existing ring, else lowest free slot (claimed and emptied), else -1
  function automatic int find_or_claim_ring(logic [15:0] key);
    int s;
    s = find_ring(key);
    if (s >= 0) return s;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_key[i]  = key;
        wr_ptr[i]    = '0;
        rd_ptr[i]    = '0;
        fill_cnt[i]  = '0;
        return i;
      end
    end
    return -1;
  endfunction

  task automatic predict_request(kemq_req_t r);
    int        s;
    int        lim;
    int        n;
    kemq_rsp_t rsp;
    case (r.req_type)
      REQ_PUSH: begin
        s = find_or_claim_ring(r.target_id);
        if (s < 0) s = find_or_claim_ring(16'd0);
        if (s >= 0) begin
          ring_mem[s][wr_ptr[s]] = r.event_data[EVENT_WIDTH-1:0];
          wr_ptr[s] = ring_next(wr_ptr[s]);
          // full ring: oldest entry is overwritten
          if (fill_cnt[s] < QUEUE_DEPTH) fill_cnt[s] = fill_cnt[s] + 1'b1;
          else rd_ptr[s] = ring_next(rd_ptr[s]);
        end
      end
      REQ_DRAIN: begin
        lim = (r.drain_limit > BATCH_MAX) ? BATCH_MAX : int'(r.drain_limit);
        s   = find_ring(r.target_id);
        n   = 0;
        if (s >= 0) n = (fill_cnt[s] < lim) ? int'(fill_cnt[s]) : lim;
        if (n == 0) begin
          rsp         = '0;
          rsp.is_last = 1'b1;
          drained_q.push_back(rsp);
        end else begin
          for (int i = 0; i < n; i++) begin
            rsp.out_event   = ring_mem[s][rd_ptr[s]];
            rsp.batch_count = n[5:0];
            rsp.has_event   = 1'b1;
            rsp.is_last     = (i == n - 1);
            drained_q.push_back(rsp);
            rd_ptr[s] = ring_next(rd_ptr[s]);
          end
          fill_cnt[s] = fill_cnt[s] - CNT_W'(n);
        end
      end
      REQ_DROP: begin
        // the controller ring is never freed
        if (r.target_id != 16'd0) begin
          s = find_ring(r.target_id);
          if (s >= 0) begin
            slot_used[s] = 1'b0;
            slot_key[s]  = '0;
            wr_ptr[s]    = '0;
            rd_ptr[s]    = '0;
            fill_cnt[s]  = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(kemq_rsp_t got);
    kemq_rsp_t exp_rsp;
    if (drained_q.size() == 0) begin
      report_mismatch($sformatf("result with none predicted, out_event %h", got.out_event));
      return;
    end
    exp_rsp = drained_q.pop_front();
    if (got.out_event !== exp_rsp.out_event)
      report_mismatch($sformatf("out_event %h, predicted %h", got.out_event, exp_rsp.out_event));
    if (got.batch_count !== exp_rsp.batch_count)
      report_mismatch($sformatf("batch_count %0d, predicted %0d",
                                got.batch_count, exp_rsp.batch_count));
    if (got.has_event !== exp_rsp.has_event)
      report_mismatch($sformatf("has_event %b, predicted %b", got.has_event, exp_rsp.has_event));
    if (got.is_last !== exp_rsp.is_last)
      report_mismatch($sformatf("is_last %b, predicted %b", got.is_last, exp_rsp.is_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        wr_ptr[i]    = '0;
        rd_ptr[i]    = '0;
        fill_cnt[i]  = '0;
        for (int j = 0; j < QUEUE_DEPTH; j++) ring_mem[i][j] = '0;
      end
      drained_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_strobe_i) check_result(rsp_i);
      if (start_i && !busy_i) predict_request(req_i);
      if (end_check_i && !end_checked) begin
        end_checked = 1'b1;
        if (drained_q.size() != 0)
          report_mismatch($sformatf("%0d predicted results never arrived", drained_q.size()));
      end
      pending_o <= drained_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for keyed_multi_ring_event_queue
// Drives directed and random push/drain/drop transactions with random sender
// gaps; kemq_scoreboard predicts every drained event and checks the results.
// ----------------------------------------------------------------------------
module tb;
  import kemq_pkg::*;

  // req_type code with no operation behind it; the block must ignore it
  localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
  localparam int         CYCLE_LIMIT   = 400_000;
  // tail after the last result: queued pushes/drops still retiring
  localparam int         SETTLE_CYCLES = 64;
  localparam int         KEY_POOL_SIZE = 12;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  kemq_req_t req_i;
  logic      rsp_strobe_o;
  kemq_rsp_t rsp_o;

  logic        end_check;
  int          mismatch_cnt;
  int          pending_cnt;
  int unsigned cycle_cnt = 0;
  int          idle_pct;
  int          items_sent;
  // small key set so that rings fill, the table fills and slots get reused
  logic [15:0] key_pool [KEY_POOL_SIZE];

  keyed_multi_ring_event_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .rsp_strobe_o (rsp_strobe_o),
    .rsp_o        (rsp_o)
  );

  kemq_scoreboard u_scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req_i),
    .rsp_strobe_i   (rsp_strobe_o),
    .rsp_i          (rsp_o),
    .end_check_i    (end_check),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // watchdog: a hung handshake or a missing result ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic kemq_req_t mk_req(logic [1:0] op, logic [15:0] key,
                                       logic [63:0] data, logic [7:0] limit);
    kemq_req_t r;
    r.req_type    = op;
    r.target_id   = key;
    r.event_data  = data;
    r.drain_limit = limit;
    return r;
  endfunction

  // any field value, including the unknown request code
  function automatic kemq_req_t random_req();
    return mk_req(2'($urandom_range(0, 3)), 16'($urandom), rand64(), 8'($urandom));
  endfunction

  // mostly legal batch sizes, some zero, some above the clamp
  function automatic logic [7:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 20) return 8'($urandom_range(BATCH_MAX + 1, 255));
    return 8'($urandom_range(1, BATCH_MAX));
  endfunction

  // One transaction. Gaps keep start low and put junk on req_i; start is
  // left high after acceptance so back-to-back items need no fresh rising edge on start.
  task automatic issue_request(kemq_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      req_i <= random_req();
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.req_type != REQ_UNKNOWN) items_sent++;
  endtask

  // one well-formed sequence with random content, or a noise item
  task automatic random_sequence();
    int          pick;
    int          idx;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    if (pick < 45) begin
      // burst of pushes, then read some back
      repeat ($urandom_range(1, 12)) issue_request(mk_req(REQ_PUSH, key, rand64(), 8'($urandom)));
      issue_request(mk_req(REQ_DRAIN, key, rand64(), pick_limit()));
    end else if (pick < 65) begin
      issue_request(mk_req(REQ_DRAIN, key, rand64(), pick_limit()));
    end else if (pick < 77) begin
      issue_request(mk_req(REQ_DROP, key, rand64(), 8'($urandom)));
    end else if (pick < 87) begin
      // retire a pool key and start a fresh one; keys 0 and all-ones stay
      idx = $urandom_range(2, KEY_POOL_SIZE - 1);
      issue_request(mk_req(REQ_DROP, key_pool[idx], rand64(), 8'($urandom)));
      key_pool[idx] = 16'($urandom);
      issue_request(mk_req(REQ_PUSH, key_pool[idx], rand64(), 8'($urandom)));
    end else begin
      issue_request(random_req());
    end
  endtask

  task automatic random_phase(int pct, int count, bit with_flood);
    int          target;
    logic [15:0] key;
    idle_pct = pct;
    target   = items_sent + count;
    if (with_flood) begin
      // wrap one ring past its depth so the oldest entries get overwritten
      key = key_pool[$urandom_range(1, KEY_POOL_SIZE - 1)];
      repeat (QUEUE_DEPTH + $urandom_range(1, 8))
        issue_request(mk_req(REQ_PUSH, key, rand64(), 8'($urandom)));
      repeat (2) issue_request(mk_req(REQ_DRAIN, key, rand64(), 8'(BATCH_MAX)));
    end
    while (items_sent < target) random_sequence();
  endtask

  initial begin
    start      <= 1'b0;
    req_i      <= '0;
    end_check  <= 1'b0;
    rst_ni     <= 1'b0;
    idle_pct   = 0;
    items_sent = 0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h0001;
    key_pool[3] = 16'h8000;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // nothing exists yet: empty drain
    issue_request(mk_req(REQ_DRAIN, 16'h0000, 64'h0, 8'd5));
    // fill all eight slots without a controller ring
    issue_request(mk_req(REQ_PUSH, 16'h0001, 64'h0, 8'd0));
    for (int k = 2; k <= 7; k++)
      issue_request(mk_req(REQ_PUSH, 16'(k), rand64(), 8'hFF));
    issue_request(mk_req(REQ_PUSH, 16'hFFFF, '1, 8'd0));
    // table full and no controller: this event is lost
    issue_request(mk_req(REQ_PUSH, 16'h00AA, 64'hA5A5_A5A5_5A5A_5A5A, 8'd0));
    issue_request(mk_req(REQ_DRAIN, 16'h00AA, rand64(), 8'd1));
    // drop of key 0 and of an absent key do nothing
    issue_request(mk_req(REQ_DROP, 16'h0000, rand64(), 8'd0));
    issue_request(mk_req(REQ_DROP, 16'h4321, rand64(), 8'd0));
    // free a slot, then the controller claims it
    issue_request(mk_req(REQ_DROP, 16'hFFFF, rand64(), 8'd0));
    issue_request(mk_req(REQ_PUSH, 16'h0000, 64'hDEAD_BEEF_0123_4567, 8'd0));
    // table full again: falls back to the controller ring
    issue_request(mk_req(REQ_PUSH, 16'h00AA, '1, 8'd0));
    // limit above the batch maximum is clamped
    issue_request(mk_req(REQ_DRAIN, 16'h0000, rand64(), 8'd255));
    issue_request(mk_req(REQ_DRAIN, 16'h0000, rand64(), 8'd3));
    // zero limit on a non-empty ring, then a single event
    issue_request(mk_req(REQ_DRAIN, 16'h0001, rand64(), 8'd0));
    issue_request(mk_req(REQ_DRAIN, 16'h0001, rand64(), 8'd1));
    // unknown request code is ignored
    issue_request(mk_req(REQ_UNKNOWN, 16'h0002, '1, 8'hFF));
    issue_request(mk_req(REQ_DROP, 16'h0000, rand64(), 8'd0));
    issue_request(mk_req(REQ_DRAIN, 16'hFFFF, rand64(), 8'd32));
    issue_request(mk_req(REQ_DRAIN, 16'h0007, rand64(), 8'd33));

    // --- random part: sender gaps 37 %, then 75 %, then none ---
    random_phase(37, 110, 1'b0);
    random_phase(75, 110, 1'b0);
    random_phase(0, 180, 1'b1);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
